@@ design/svpwm_pkg.sv @@
// Shared types and constants for the space vector PWM duty generator.
// No dependencies; compiled before every other design file.
package svpwm_pkg;

   localparam int IN_W   = 16;
   localparam int DUTY_W = 15;
   localparam int SEC_W  = 3;

   // 1/sqrt(3) in unsigned Q0.30.
   localparam logic [29:0] INV_SQRT3_Q30 = 30'd619925131;

   // Sextant codes, named after the two active vectors that bound them.
   localparam logic [SEC_W-1:0] SEC_V1_V2 = 3'd0;
   localparam logic [SEC_W-1:0] SEC_V2_V3 = 3'd1;
   localparam logic [SEC_W-1:0] SEC_V3_V4 = 3'd2;
   localparam logic [SEC_W-1:0] SEC_V4_V5 = 3'd3;
   localparam logic [SEC_W-1:0] SEC_V5_V6 = 3'd4;
   localparam logic [SEC_W-1:0] SEC_V6_V1 = 3'd5;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_a;
      logic [DUTY_W-1:0] duty_b;
      logic [DUTY_W-1:0] duty_c;
      logic [SEC_W-1:0]  sector;
      logic              in_range;
   } svpwm_duty_type;

endpackage

@@ design/svpwm_if.sv @@
// Valid/ready channel interfaces for the space vector PWM duty generator.
// Depends on svpwm_pkg for the field widths.
interface svpwm_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [svpwm_pkg::IN_W-1:0]   vec_alpha;
   logic signed [svpwm_pkg::IN_W-1:0]   vec_beta;

   modport source (output valid, output vec_alpha, output vec_beta, input ready);
   modport sink   (input valid, input vec_alpha, input vec_beta, output ready);
endinterface

interface svpwm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [svpwm_pkg::DUTY_W-1:0]  duty_a;
   logic [svpwm_pkg::DUTY_W-1:0]  duty_b;
   logic [svpwm_pkg::DUTY_W-1:0]  duty_c;
   logic [svpwm_pkg::SEC_W-1:0]   sector;
   logic                          in_range;

   modport source (output valid, output duty_a, output duty_b, output duty_c,
                   output sector, output in_range, input ready);
   modport sink   (input valid, input duty_a, input duty_b, input duty_c,
                   input sector, input in_range, output ready);
endinterface

@@ design/svpwm_duty.sv @@
// Per-sextant on-time and centered duty calculation, with saturation.
// Combinational; depends on svpwm_pkg for widths, sextant codes and result type.
module svpwm_duty #(
   parameter int FRAC_BITS = 14
) (
   input  logic [svpwm_pkg::SEC_W-1:0]       sector,
   input  logic signed [svpwm_pkg::IN_W-1:0] vec_alpha,
   input  logic signed [17:0]                beta_s3,
   input  logic signed [17:0]                beta_2s3,
   output svpwm_pkg::svpwm_duty_type         result
);

   // Doubled duties stay within one + 2^17 in magnitude.
   localparam int DW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
   localparam logic signed [DW-1:0] ONE     = {{(DW-1){1'b0}}, 1'b1} << FRAC_BITS;
   localparam logic signed [DW-1:0] TWO_ONE = ONE <<< 1;

   logic signed [DW-1:0] a_x, b3_x, b23_x;
   logic signed [DW-1:0] x, y, base, ta, tb, tc;

   function automatic logic [svpwm_pkg::DUTY_W-1:0] halve_sat(
      input logic signed [DW-1:0] d2);
      logic signed [DW-1:0] c;
      logic [DW-1:0]        r;
      c = d2;
      if (d2 < 0) begin
         c = '0;
      end else if (d2 > TWO_ONE) begin
         c = TWO_ONE;
      end
      r = ($unsigned(c) + DW'(1)) >> 1;
      return r[svpwm_pkg::DUTY_W-1:0];
   endfunction

   assign a_x   = DW'(vec_alpha);
   assign b3_x  = DW'(beta_s3);
   assign b23_x = DW'(beta_2s3);

   always_comb begin
      x = '0;
      y = '0;
      case (sector)
         svpwm_pkg::SEC_V1_V2: begin x = a_x - b3_x;  y = b23_x;         end
         svpwm_pkg::SEC_V2_V3: begin x = a_x + b3_x;  y = b3_x - a_x;    end
         svpwm_pkg::SEC_V3_V4: begin x = b23_x;       y = -a_x - b3_x;   end
         svpwm_pkg::SEC_V4_V5: begin x = b3_x - a_x;  y = -b23_x;        end
         svpwm_pkg::SEC_V5_V6: begin x = -a_x - b3_x; y = a_x - b3_x;    end
         default:              begin x = -b23_x;      y = a_x + b3_x;    end
      endcase
      base = ONE - x - y;
      ta = base;
      tb = base;
      tc = base;
      // The smallest duty is the base; the others follow by adding twice
      // the on-times in the switching order of the sextant.
      case (sector)
         svpwm_pkg::SEC_V1_V2: begin tb = base + (x <<< 1); tc = tb + (y <<< 1); end
         svpwm_pkg::SEC_V2_V3: begin ta = base + (y <<< 1); tc = ta + (x <<< 1); end
         svpwm_pkg::SEC_V3_V4: begin tc = base + (x <<< 1); ta = tc + (y <<< 1); end
         svpwm_pkg::SEC_V4_V5: begin tb = base + (y <<< 1); ta = tb + (x <<< 1); end
         svpwm_pkg::SEC_V5_V6: begin ta = base + (x <<< 1); tb = ta + (y <<< 1); end
         default:              begin tc = base + (y <<< 1); tb = tc + (x <<< 1); end
      endcase
   end

   assign result.duty_a   = halve_sat(ta);
   assign result.duty_b   = halve_sat(tb);
   assign result.duty_c   = halve_sat(tc);
   assign result.sector   = sector;
   assign result.in_range = !((ta < 0) || (ta > TWO_ONE) ||
                              (tb < 0) || (tb > TWO_ONE) ||
                              (tc < 0) || (tc > TWO_ONE));

endmodule

@@ design/space_vector_pwm_duty_top.sv @@
// Space vector PWM duty generator, top level: pipeline registers and flow control.
// Depends on svpwm_pkg, svpwm_req_if / svpwm_rsp_if and svpwm_duty.
//
// Usage:
//   req_chan carries one alpha/beta modulation vector per transaction, signed,
//   with FRAC_BITS fraction bits. rsp_chan returns one transaction per request:
//   three centered phase duties (full scale is 1 << FRAC_BITS), the sextant
//   and an in_range flag that is low when a duty had to be saturated.
//   The block is a four-register pipeline (input, product, sextant and beta
//   terms, result) and takes one transaction every cycle while rsp_chan.ready
//   is high; the 17x30 bit multiply by 1/sqrt(3) has a stage of its own.
//   Each stage advances when the stage after it is empty or moving, so a
//   stalled receiver holds the result and fills the empty stages behind it;
//   req_chan.ready drops only once all four stages hold data.
//   Synchronous reset empties the pipeline; no results are pending after it.
module space_vector_pwm_duty_top #(
   parameter int FRAC_BITS = 14
) (
   input logic         clock,
   input logic         reset,
   svpwm_req_if.sink   req_chan,
   svpwm_rsp_if.source rsp_chan
);

   localparam int IN_W = svpwm_pkg::IN_W;

   // Stage valids and stage-enable terms.
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic rdy1, rdy2, rdy3, rdy4;

   // Stage 1: input register.
   logic signed [IN_W-1:0] a1_ff, b1_ff;
   // Stage 2: product |beta| * 1/sqrt(3) in Q30.
   logic signed [IN_W-1:0] a2_ff;
   logic                   bneg2_ff;
   logic [46:0]            prod_ff, prod_in;
   logic [16:0]            bmag1;
   // Stage 3: sextant and rounded beta terms.
   logic signed [IN_W-1:0] a3_ff;
   logic signed [17:0]     b3_ff, b3_in, b23_ff, b23_in;
   logic [svpwm_pkg::SEC_W-1:0] sec_ff, sec_in;
   logic [16:0]            amag2;
   logic [46:0]            athr, rsum1;
   logic [47:0]            rsum2;
   logic                   p_gt, p_lt;
   // Stage 4: result register.
   svpwm_pkg::svpwm_duty_type res_ff, res_in;

   assign rdy4 = !v4_ff || rsp_chan.ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_chan.ready = rdy1;

   assign v1_in = rdy1 ? req_chan.valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;
   assign v4_in = rdy4 ? v3_ff : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // Stage 1 -> 2: magnitude product.
   assign bmag1   = b1_ff[IN_W-1] ? (17'd0 - {b1_ff[IN_W-1], b1_ff})
                                  : {b1_ff[IN_W-1], b1_ff};
   assign prod_in = 47'(bmag1) * 47'(svpwm_pkg::INV_SQRT3_Q30);

   // Stage 2 -> 3: sextant from comparing |beta|/sqrt(3) against |alpha|.
   assign amag2 = a2_ff[IN_W-1] ? (17'd0 - {a2_ff[IN_W-1], a2_ff})
                                : {a2_ff[IN_W-1], a2_ff};
   assign athr  = {amag2, 30'd0};
   assign p_gt  = prod_ff > athr;
   assign p_lt  = prod_ff < athr;

   always_comb begin
      if (!bneg2_ff) begin
         if (!a2_ff[IN_W-1]) begin
            sec_in = p_gt ? svpwm_pkg::SEC_V2_V3 : svpwm_pkg::SEC_V1_V2;
         end else begin
            sec_in = p_lt ? svpwm_pkg::SEC_V3_V4 : svpwm_pkg::SEC_V2_V3;
         end
      end else begin
         if (!a2_ff[IN_W-1]) begin
            sec_in = p_gt ? svpwm_pkg::SEC_V5_V6 : svpwm_pkg::SEC_V6_V1;
         end else begin
            sec_in = p_lt ? svpwm_pkg::SEC_V4_V5 : svpwm_pkg::SEC_V5_V6;
         end
      end
   end

   // Round the magnitudes to nearest, then restore the sign of beta, which
   // gives ties away from zero.
   assign rsum1  = prod_ff + 47'(1 << 29);
   assign rsum2  = {prod_ff, 1'b0} + 48'(1 << 29);
   assign b3_in  = bneg2_ff ? (18'sd0 - $signed({1'b0, rsum1[46:30]}))
                            : $signed({1'b0, rsum1[46:30]});
   assign b23_in = bneg2_ff ? (18'sd0 - $signed({1'b0, rsum2[46:30]}))
                            : $signed({1'b0, rsum2[46:30]});

   // Stage 3 -> 4: duties.
   svpwm_duty #(
      .FRAC_BITS (FRAC_BITS)
   ) u_duty (
      .sector    (sec_ff),
      .vec_alpha (a3_ff),
      .beta_s3   (b3_ff),
      .beta_2s3  (b23_ff),
      .result    (res_in)
   );

   always_ff @(posedge clock) begin
      if (rdy1 && req_chan.valid) begin
         a1_ff <= req_chan.vec_alpha;
         b1_ff <= req_chan.vec_beta;
      end
      if (rdy2 && v1_ff) begin
         a2_ff    <= a1_ff;
         bneg2_ff <= b1_ff[IN_W-1];
         prod_ff  <= prod_in;
      end
      if (rdy3 && v2_ff) begin
         a3_ff  <= a2_ff;
         b3_ff  <= b3_in;
         b23_ff <= b23_in;
         sec_ff <= sec_in;
      end
      if (rdy4 && v3_ff) begin
         res_ff <= res_in;
      end
   end

   assign rsp_chan.valid    = v4_ff;
   assign rsp_chan.duty_a   = res_ff.duty_a;
   assign rsp_chan.duty_b   = res_ff.duty_b;
   assign rsp_chan.duty_c   = res_ff.duty_c;
   assign rsp_chan.sector   = res_ff.sector;
   assign rsp_chan.in_range = res_ff.in_range;

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("result valid right after reset");

   // A stage that cannot pass its transaction on keeps it.
   a_stage3_hold: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !rdy4) |=> (v3_ff && $stable(sec_ff) && $stable(b3_ff)))
      else $error("stage 3 transaction lost under stall");

   // Saturated duties never exceed full scale where the field holds it.
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> ((FRAC_BITS > 14) ||
         ((32'(rsp_chan.duty_a) <= (32'd1 << FRAC_BITS)) &&
          (32'(rsp_chan.duty_b) <= (32'd1 << FRAC_BITS)) &&
          (32'(rsp_chan.duty_c) <= (32'd1 << FRAC_BITS)))))
      else $error("duty above full scale");

endmodule

@@ tb/tb_space_vector_pwm_duty_top.sv @@
// Testbench for space_vector_pwm_duty_top: sends alpha/beta vectors, predicts the
// three phase duties, sextant and range flag, and checks every result in order.
// Depends on svpwm_pkg, svpwm_req_if / svpwm_rsp_if and the design top level.
module tb_space_vector_pwm_duty_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS  = 14;
   localparam int WATCHDOG   = 1000;
   localparam int DRAIN_WAIT = 12;
   localparam int IN_W       = svpwm_pkg::IN_W;
   localparam int DUTY_W     = svpwm_pkg::DUTY_W;
   localparam int SEC_W      = svpwm_pkg::SEC_W;

   logic clock;
   logic reset;

   svpwm_req_if req_chan ();
   svpwm_rsp_if rsp_chan ();

   space_vector_pwm_duty_top #(
      .FRAC_BITS(FRAC_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   svpwm_pkg::svpwm_duty_type expected_duties[$];
   int             errors      = 0;
   int             quiet_count = 0;
   bit             gaps_on     = 1'b1;
   int             stall_left  = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Rounds x * k / 2^30 to nearest, ties away from zero.
   function automatic longint round_q30_product(input longint x, input longint k);
      longint mag;
      longint r;
      mag = (x < 0) ? -x : x;
      r   = (mag * k + (longint'(1) <<< 29)) >>> 30;
      return (x < 0) ? -r : r;
   endfunction

   // Takes a duty at twice its scale, saturates it into 0..1 and halves it.
   function automatic logic [DUTY_W-1:0] halve_duty(input longint d2, input longint one,
                                                    inout bit ok);
      longint v;
      v = d2;
      if (v < 0) begin
         ok = 1'b0;
         v  = 0;
      end
      if (v > 2 * one) begin
         ok = 1'b0;
         v  = 2 * one;
      end
      return DUTY_W'((v + 1) >>> 1);
   endfunction

   function automatic svpwm_pkg::svpwm_duty_type predict_duty(
      input logic signed [IN_W-1:0] alpha,
      input logic signed [IN_W-1:0] beta);
      longint         one, a, b, bk, a30, b3, b23, x, y, ta, tb, tc;
      logic [SEC_W-1:0] sec;
      bit             ok;
      svpwm_pkg::svpwm_duty_type r;
      one = longint'(1) <<< FRAC_BITS;
      a   = alpha;
      b   = beta;
      bk  = b * longint'(svpwm_pkg::INV_SQRT3_Q30);
      a30 = a * (longint'(1) <<< 30);
      b3  = round_q30_product(b, longint'(svpwm_pkg::INV_SQRT3_Q30));
      b23 = round_q30_product(b, 2 * longint'(svpwm_pkg::INV_SQRT3_Q30));
      ok  = 1'b1;

      if (b >= 0) begin
         if (a >= 0) sec = (bk > a30) ? svpwm_pkg::SEC_V2_V3 : svpwm_pkg::SEC_V1_V2;
         else        sec = (-bk > a30) ? svpwm_pkg::SEC_V3_V4 : svpwm_pkg::SEC_V2_V3;
      end else begin
         if (a >= 0) sec = (-bk > a30) ? svpwm_pkg::SEC_V5_V6 : svpwm_pkg::SEC_V6_V1;
         else        sec = (bk > a30) ? svpwm_pkg::SEC_V4_V5 : svpwm_pkg::SEC_V5_V6;
      end

      // All on-times below are at twice the duty scale.
      case (sec)
         svpwm_pkg::SEC_V1_V2: begin
            x = a - b3;   y = b23;
            ta = one - x - y; tb = ta + 2 * x; tc = tb + 2 * y;
         end
         svpwm_pkg::SEC_V2_V3: begin
            x = a + b3;   y = -a + b3;
            tb = one - x - y; ta = tb + 2 * y; tc = ta + 2 * x;
         end
         svpwm_pkg::SEC_V3_V4: begin
            x = b23;      y = -a - b3;
            tb = one - x - y; tc = tb + 2 * x; ta = tc + 2 * y;
         end
         svpwm_pkg::SEC_V4_V5: begin
            x = -a + b3;  y = -b23;
            tc = one - x - y; tb = tc + 2 * y; ta = tb + 2 * x;
         end
         svpwm_pkg::SEC_V5_V6: begin
            x = -a - b3;  y = a - b3;
            tc = one - x - y; ta = tc + 2 * x; tb = ta + 2 * y;
         end
         default: begin
            x = -b23;     y = a + b3;
            ta = one - x - y; tc = ta + 2 * y; tb = tc + 2 * x;
         end
      endcase

      r.duty_a   = halve_duty(ta, one, ok);
      r.duty_b   = halve_duty(tb, one, ok);
      r.duty_c   = halve_duty(tc, one, ok);
      r.sector   = sec;
      r.in_range = ok;
      return r;
   endfunction

   function automatic logic signed [IN_W-1:0] clip_component(input int v);
      if (v > 32767)  return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return IN_W'(v);
   endfunction

   // Drives one vector and waits until the transaction is accepted.
   task automatic send_vector(input logic signed [IN_W-1:0] alpha,
                              input logic signed [IN_W-1:0] beta);
      int gap;
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid     <= 1'b1;
      req_chan.vec_alpha <= alpha;
      req_chan.vec_beta  <= beta;
      do @(posedge clock); while (!req_chan.ready);
      expected_duties.push_back(predict_duty(alpha, beta));
   endtask

   task automatic check_field(input string name, input int exp_value, input int act_value);
      if (exp_value != act_value) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_value, act_value);
         errors++;
      end
   endtask

   // Receiver side: random stall bursts while gaps are enabled.
   initial begin
      rsp_chan.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (stall_left > 0) stall_left--;
         else if (gaps_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
         rsp_chan.ready <= (stall_left == 0);
      end
   end

   always @(posedge clock) begin
      svpwm_pkg::svpwm_duty_type exp_duty;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_duties.size() == 0) begin
            $error("result transaction arrived with no request outstanding");
            errors++;
         end else begin
            exp_duty = expected_duties.pop_front();
            check_field("duty_a", int'(exp_duty.duty_a), int'(rsp_chan.duty_a));
            check_field("duty_b", int'(exp_duty.duty_b), int'(rsp_chan.duty_b));
            check_field("duty_c", int'(exp_duty.duty_c), int'(rsp_chan.duty_c));
            check_field("sector", int'(exp_duty.sector), int'(rsp_chan.sector));
            check_field("in_range", int'(exp_duty.in_range), int'(rsp_chan.in_range));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_count <= 0;
      else
         quiet_count <= quiet_count + 1;
      if (quiet_count >= WATCHDOG) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic test_zero_vector();
      send_vector(16'sd0, 16'sd0);
   endtask

   task automatic test_extremes();
      send_vector(16'sd32767, 16'sd0);
      send_vector(-16'sd32768, 16'sd0);
      send_vector(16'sd0, 16'sd32767);
      send_vector(16'sd0, -16'sd32768);
      send_vector(16'sd32767, 16'sd32767);
      send_vector(-16'sd32768, -16'sd32768);
      send_vector(16'sd32767, -16'sd32768);
      send_vector(-16'sd32768, 16'sd32767);
      send_vector(16'sd1, 16'sd0);
      send_vector(-16'sd1, 16'sd0);
      send_vector(16'sd0, 16'sd1);
      send_vector(16'sd0, -16'sd1);
   endtask

   // Vectors on either side of the sextant lines, and a duty just at and
   // just past full scale.
   task automatic test_sextant_edges();
      send_vector(16'sd8192, 16'sd14188);
      send_vector(16'sd8192, 16'sd14189);
      send_vector(-16'sd8192, 16'sd14188);
      send_vector(-16'sd8192, 16'sd14189);
      send_vector(-16'sd8192, -16'sd14189);
      send_vector(16'sd8192, -16'sd14189);
      send_vector(16'sd16384, 16'sd0);
      send_vector(16'sd16385, 16'sd0);
   endtask

   task automatic test_random_hexagon(input int count);
      for (int i = 0; i < count; i++)
         send_vector(IN_W'($urandom_range(0, 28000)) - 16'sd14000,
                     IN_W'($urandom_range(0, 28000)) - 16'sd14000);
   endtask

   task automatic test_random_full(input int count);
      for (int i = 0; i < count; i++)
         send_vector(IN_W'($urandom), IN_W'($urandom));
   endtask

   // Points close to the sextant lines beta = +-sqrt3 * alpha and to both axes.
   task automatic test_random_boundaries(input int count);
      int a;
      int b;
      int d;
      for (int i = 0; i < count; i++) begin
         d = $urandom_range(0, 6) - 3;
         case ($urandom_range(0, 2))
            0: begin
               a = $urandom_range(0, 37000) - 18500;
               b = (a * 28378) >>> 14;
               if ($urandom_range(0, 1)) b = -b;
               b = b + d;
            end
            1: begin
               a = d;
               b = $urandom_range(0, 65535) - 32768;
            end
            default: begin
               a = $urandom_range(0, 65535) - 32768;
               b = d;
            end
         endcase
         send_vector(clip_component(a), clip_component(b));
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.vec_alpha = '0;
      req_chan.vec_beta  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_zero_vector();
      test_extremes();
      test_sextant_edges();
      test_random_hexagon(180);
      test_random_full(80);
      test_random_boundaries(80);
      // Final stretch runs at full rate on both sides.
      gaps_on = 1'b0;
      test_random_hexagon(60);

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_duties.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

@@ space_vector_pwm_duty_top.f @@
design/svpwm_pkg.sv
design/svpwm_if.sv
design/svpwm_duty.sv
design/space_vector_pwm_duty_top.sv
tb/tb_space_vector_pwm_duty_top.sv
